// File: hw/rtl/psot_pkg.sv
`timescale 1ns / 1ps

package psot_pkg;

    localparam int PSOT_CHANNELS   = 16;
    localparam int PSOT_LIST_DEPTH = 16;
    localparam int PSOT_ID_BITS    = 16;

    localparam logic [2:0] REQ_SET_MODE   = 3'd0;
    localparam logic [2:0] REQ_ADD_ID     = 3'd1;
    localparam logic [2:0] REQ_CHECK      = 3'd2;
    localparam logic [2:0] REQ_FINISH     = 3'd3;
    localparam logic [2:0] REQ_QUERY_MODE = 3'd4;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_RELAXED  = 2'd1;
    localparam logic [1:0] KIND_STRONG   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_TARGET  = 2'd1;
    localparam logic [1:0] MODE_LITE    = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  channel_index;
        logic [15:0] work_id;
        logic [1:0]  order_kind;
        logic [1:0]  mode_in;
    } req_word_t;

    typedef struct packed {
        logic       may_proceed;
        logic [1:0] mode_out;
        logic [1:0] status;
        logic [4:0] list_count;
    } rsp_word_t;

endpackage

// File: hw/rtl/psot_list_ram.sv
`timescale 1ns / 1ps

module psot_list_ram #(
    parameter int AW = 8,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/psot_ctrl.sv
`timescale 1ns / 1ps

module psot_ctrl #(
    parameter int CHANNELS   = 16,
    parameter int LIST_DEPTH = 16,
    parameter int ID_BITS    = 16,
    localparam int NCH = (CHANNELS < 16) ? CHANNELS : 16,
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1,
    localparam int IW  = $clog2(LIST_DEPTH),
    localparam int AW  = CHW + IW,
    localparam int IDW = (ID_BITS < 16) ? ID_BITS : 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  psot_pkg::req_word_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output psot_pkg::rsp_word_t   rsp,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [IDW-1:0]        mem_wdata,
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr,
    input  logic [IDW-1:0]        mem_rdata
);

    import psot_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_HEAD = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    req_word_t     req_q_reg, req_q_next;
    logic          ch_ok_reg, ch_ok_next;
    logic          may_reg, may_next;
    logic [1:0]    status_reg, status_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_idx_reg, pend_idx_next;
    logic          found_reg, found_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_word_t     rsp_reg, rsp_next;

    logic          mode_set_reg [NCH];
    logic          mode_set_next [NCH];
    logic [1:0]    mode_reg [NCH];
    logic [1:0]    mode_next [NCH];
    logic [CW-1:0] cnt_reg [NCH];
    logic [CW-1:0] cnt_next [NCH];

    logic [CHW-1:0] ch;
    logic           cur_set;
    logic [1:0]     cur_mode;
    logic [CW-1:0]  cur_cnt;
    logic [1:0]     eff_mode;
    logic           ordered;
    logic [IDW-1:0] id_q;
    logic           hit;

    assign ch       = req_q_reg.channel_index[CHW-1:0];
    assign cur_set  = mode_set_reg[ch];
    assign cur_mode = mode_reg[ch];
    assign cur_cnt  = cnt_reg[ch];
    assign eff_mode = cur_set ? cur_mode : MODE_INIT;
    assign ordered  = (req_q_reg.order_kind == KIND_RELAXED) ||
                      (req_q_reg.order_kind == KIND_STRONG);
    assign id_q     = req_q_reg.work_id[IDW-1:0];
    assign hit      = (mem_rdata == id_q);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_q_next     = req_q_reg;
        ch_ok_next     = ch_ok_reg;
        may_next       = may_reg;
        status_next    = status_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mode_set_next  = mode_set_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = id_q;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_q_next  = req;
                    ch_ok_next  = (32'(req.channel_index) < CHANNELS);
                    may_next    = 1'b0;
                    status_next = STAT_OK;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                if (ch_ok_reg)
                begin
                    case (req_q_reg.req_type)
                        REQ_SET_MODE:
                        begin
                            if (req_q_reg.mode_in != MODE_INVALID)
                            begin
                                mode_set_next[ch] = 1'b1;
                                mode_next[ch]     = req_q_reg.mode_in;
                            end
                        end
                        REQ_ADD_ID:
                        begin
                            mode_set_next[ch] = 1'b1;
                            mode_next[ch]     = eff_mode;
                            if (eff_mode == MODE_INIT && ordered)
                            begin
                                if (cur_cnt >= CW'(LIST_DEPTH))
                                begin
                                    status_next = STAT_FULL;
                                end
                                else
                                begin
                                    mem_we       = 1'b1;
                                    mem_waddr    = {ch, cur_cnt[IW-1:0]};
                                    cnt_next[ch] = cur_cnt + CW'(1);
                                end
                            end
                        end
                        REQ_CHECK:
                        begin
                            if (!cur_set)
                            begin
                                may_next = 1'b0;
                            end
                            else if (cur_mode != MODE_INIT || !ordered)
                            begin
                                may_next = 1'b1;
                            end
                            else if (cur_cnt == '0)
                            begin
                                status_next = STAT_EMPTY;
                                may_next    = (req_q_reg.order_kind == KIND_RELAXED);
                            end
                            else if (req_q_reg.order_kind == KIND_RELAXED)
                            begin
                                may_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = {ch, {IW{1'b0}}};
                                state_next = ST_HEAD;
                            end
                        end
                        REQ_FINISH:
                        begin
                            if (cur_set && cur_mode == MODE_INIT && cur_cnt != '0)
                            begin
                                rd_idx_next = '0;
                                pend_next   = 1'b0;
                                found_next  = 1'b0;
                                state_next  = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_HEAD:
            begin
                may_next   = hit;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // read one entry a cycle; after the match, each entry moves down one slot
                if (rd_idx_reg < cur_cnt)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = {ch, rd_idx_reg[IW-1:0]};
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {ch, IW'(pend_idx_reg - CW'(1))};
                        mem_wdata = mem_rdata;
                    end
                    else if (hit)
                    begin
                        found_next = 1'b1;
                    end
                    if (rd_idx_reg == cur_cnt)
                    begin
                        if (found_reg || hit)
                        begin
                            cnt_next[ch] = cur_cnt - CW'(1);
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.may_proceed = may_reg;
                    rsp_next.mode_out    = (ch_ok_reg && cur_set) ? cur_mode : MODE_INIT;
                    rsp_next.status      = status_reg;
                    rsp_next.list_count  = ch_ok_reg ? 5'(cur_cnt) : 5'd0;
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            ch_ok_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            for (int i = 0; i < NCH; i++)
            begin
                mode_set_reg[i] <= 1'b0;
                mode_reg[i]     <= MODE_INIT;
                cnt_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            ch_ok_reg     <= ch_ok_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rd_idx_reg    <= rd_idx_next;
            mode_set_reg  <= mode_set_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_q_reg    <= req_q_next;
        may_reg      <= may_next;
        status_reg   <= status_next;
        pend_idx_reg <= pend_idx_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// File: hw/rtl/per_channel_strong_order_tracker_top.sv
`timescale 1ns / 1ps
// Sequence: a taken request passes EXEC then DONE (set, add, query, most checks, finish
// with nothing to scan), EXEC, HEAD, DONE for a strong check on a non-empty list and
// EXEC, SCAN, DONE for a finish that scans (count <= LIST_DEPTH), one list entry per cycle.
// Throughput: one request in flight; the next can be taken as soon as its response word is
// posted, and a stalled response word holds the request behind it in its DONE state.
// Reset: rst_n async, active low; all channels unset with empty lists; list memory kept.

module per_channel_strong_order_tracker_top #(
    parameter int CHANNELS   = psot_pkg::PSOT_CHANNELS,
    parameter int LIST_DEPTH = psot_pkg::PSOT_LIST_DEPTH,
    parameter int ID_BITS    = psot_pkg::PSOT_ID_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  psot_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output psot_pkg::rsp_word_t rsp
);

    import psot_pkg::*;

    localparam int NCH = (CHANNELS < 16) ? CHANNELS : 16;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IW  = $clog2(LIST_DEPTH);
    localparam int AW  = CHW + IW;
    localparam int IDW = (ID_BITS < 16) ? ID_BITS : 16;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [IDW-1:0] mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [IDW-1:0] mem_rdata;

    psot_ctrl #(
        .CHANNELS   (CHANNELS),
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    psot_list_ram #(
        .AW (AW),
        .DW (IDW)
    ) u_list_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// File: hw/rtl/psot_checker.sv
`timescale 1ns / 1ps

module psot_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input psot_pkg::req_word_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input psot_pkg::rsp_word_t rsp
);

    import psot_pkg::*;

    // response word holds while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // one request in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // a dropped add only happens in initiator-ordered mode
    a_full_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |-> rsp.mode_out == MODE_INIT && !rsp.may_proceed)
        else $error("list-full status outside initiator-ordered mode");

    // empty-list status reports an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_EMPTY |-> rsp.list_count == 5'd0)
        else $error("empty-list status with non-zero count");

endmodule

bind per_channel_strong_order_tracker_top psot_checker u_psot_checker (.*);
